/* src/assert_macros.svh */
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/sthd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the trend hazard detector.
package sthd_pkg;

    localparam int WINDOW_DEF = 5;

    localparam int TEMP_W   = 16;
    localparam int HUM_W    = 14;
    localparam int AIR_W    = 10;
    localparam int TMARG_W  = 15;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_TEMP_MARGIN = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HUM_MARGIN  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_AIR_MARGIN  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TEMP_LIMIT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_AIR_LIMIT   = 3'd4;

    localparam logic [TMARG_W-1:0]       RST_TEMP_MARGIN = 15'd50;
    localparam logic [HUM_W-1:0]         RST_HUM_MARGIN  = 14'd200;
    localparam logic [AIR_W-1:0]         RST_AIR_MARGIN  = 10'd10;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT  = 16'sd4500;
    localparam logic [AIR_W-1:0]         RST_AIR_LIMIT   = 10'd200;

    typedef enum logic [1:0] {
        HZ_NONE     = 2'd0,
        HZ_TEMP     = 2'd1,
        HZ_HUMIDITY = 2'd2,
        HZ_AIR      = 2'd3
    } t_hazard;

    typedef struct packed {
        logic [TMARG_W-1:0]       temp_margin;
        logic [HUM_W-1:0]         hum_margin;
        logic [AIR_W-1:0]         air_margin;
        logic signed [TEMP_W-1:0] temp_limit;
        logic [AIR_W-1:0]         air_limit;
    } t_cfg;

    // What one reading leaves in the window.
    typedef struct packed {
        logic valid;
        logic temp_step;
        logic hum_step;
        logic air_step;
        logic temp_exceed;
        logic air_exceed;
    } t_flags;

endpackage

/* src/sthd_step.sv */
`timescale 1ns / 1ps
// Step and threshold evaluation of a new reading against the previous one.
module sthd_step
    import sthd_pkg::*;
(
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [HUM_W-1:0]         i_humidity,
    input  logic [AIR_W-1:0]         i_air_quality,
    input  logic signed [TEMP_W-1:0] i_prev_temperature,
    input  logic [HUM_W-1:0]         i_prev_humidity,
    input  logic [AIR_W-1:0]         i_prev_air_quality,
    input  logic                     i_have_prev,
    input  t_cfg                     i_cfg,
    output t_flags                   o_flags
);

    logic signed [TEMP_W:0] w_temp_diff;
    logic signed [HUM_W:0]  w_hum_diff;
    logic signed [AIR_W:0]  w_air_diff;

    assign w_temp_diff = {i_temperature[TEMP_W-1], i_temperature}
                       - {i_prev_temperature[TEMP_W-1], i_prev_temperature};
    assign w_hum_diff  = $signed({1'b0, i_humidity}) - $signed({1'b0, i_prev_humidity});
    assign w_air_diff  = $signed({1'b0, i_air_quality}) - $signed({1'b0, i_prev_air_quality});

    always_comb begin
        o_flags.valid       = 1'b1;
        o_flags.temp_step   = i_have_prev && (w_temp_diff > 17'sd0)
                            && (w_temp_diff >= $signed({2'b00, i_cfg.temp_margin}));
        o_flags.hum_step    = i_have_prev && (w_hum_diff > 15'sd0)
                            && (w_hum_diff >= $signed({1'b0, i_cfg.hum_margin}));
        o_flags.air_step    = i_have_prev && (w_air_diff > 11'sd0)
                            && (w_air_diff >= $signed({1'b0, i_cfg.air_margin}));
        o_flags.temp_exceed = i_temperature > i_cfg.temp_limit;
        o_flags.air_exceed  = i_air_quality > i_cfg.air_limit;
    end

endmodule

/* src/sthd_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds the flags of one past reading and passes them on.
module sthd_cell
    import sthd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_flags i_flags,
    output t_flags o_flags
);

    t_flags r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_shift) begin
            r_flags <= i_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

/* src/sensor_trend_hazard_detector.sv */
`timescale 1ns / 1ps
// Top level of the sensor trend hazard detector.
//
//  channel  direction  handshake                payload
//  in       request    i_in_valid / o_in_stall  i_temperature, i_humidity, i_air_quality
//  out      result     o_out_valid / i_out_stall o_hazard_code
//  cfg      write      i_cfg_we                 i_cfg_index, i_cfg_data
//
// One reading is taken per cycle while the input is not stalled; its hazard code appears in the cycle after acceptance.
// The window is a row of WINDOW-1 cells that shift once per accepted reading.
// No code is given until WINDOW readings have arrived since reset.
// Reset clears the cells and the output valid flag and restores the configuration register defaults.
// The input stalls only while a code waits in the output register and is itself stalled.
module sensor_trend_hazard_detector
    import sthd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [HUM_W-1:0]         i_humidity,
    input  logic [AIR_W-1:0]         i_air_quality,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_hazard_code,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cfg                     r_cfg;
    logic signed [TEMP_W-1:0] r_prev_temperature;
    logic [HUM_W-1:0]         r_prev_humidity;
    logic [AIR_W-1:0]         r_prev_air_quality;
    logic                     r_out_valid;
    t_hazard                  r_code;
    t_hazard                  n_code;

    t_flags w_new;
    t_flags w_cell [WINDOW-1];
    logic   w_in_accept;
    logic   w_full;
    logic   w_temp_rise;
    logic   w_hum_rise;
    logic   w_air_rise;
    logic   w_temp_exc;
    logic   w_air_exc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_margin <= RST_TEMP_MARGIN;
            r_cfg.hum_margin  <= RST_HUM_MARGIN;
            r_cfg.air_margin  <= RST_AIR_MARGIN;
            r_cfg.temp_limit  <= RST_TEMP_LIMIT;
            r_cfg.air_limit   <= RST_AIR_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_MARGIN: r_cfg.temp_margin <= i_cfg_data[TMARG_W-1:0];
                CFG_HUM_MARGIN:  r_cfg.hum_margin  <= i_cfg_data[HUM_W-1:0];
                CFG_AIR_MARGIN:  r_cfg.air_margin  <= i_cfg_data[AIR_W-1:0];
                CFG_TEMP_LIMIT:  r_cfg.temp_limit  <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_AIR_LIMIT:   r_cfg.air_limit   <= i_cfg_data[AIR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_prev_temperature <= i_temperature;
            r_prev_humidity    <= i_humidity;
            r_prev_air_quality <= i_air_quality;
        end
    end

    sthd_step u_step (
        .i_temperature      (i_temperature),
        .i_humidity         (i_humidity),
        .i_air_quality      (i_air_quality),
        .i_prev_temperature (r_prev_temperature),
        .i_prev_humidity    (r_prev_humidity),
        .i_prev_air_quality (r_prev_air_quality),
        .i_have_prev        (w_cell[0].valid),
        .i_cfg              (r_cfg),
        .o_flags            (w_new)
    );

    for (genvar g = 0; g < WINDOW - 1; g++) begin : g_cell
        if (g == 0) begin : g_head
            sthd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_accept),
                .i_flags (w_new),
                .o_flags (w_cell[g])
            );
        end else begin : g_body
            sthd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_in_accept),
                .i_flags (w_cell[g-1]),
                .o_flags (w_cell[g])
            );
        end
    end

    // The window is the new reading plus all cells; the oldest cell's step
    // points outside the window and is not used.
    always_comb begin
        w_temp_rise = w_new.temp_step;
        w_hum_rise  = w_new.hum_step;
        w_air_rise  = w_new.air_step;
        w_temp_exc  = w_new.temp_exceed;
        w_air_exc   = w_new.air_exceed;
        for (int k = 0; k < WINDOW - 2; k++) begin
            w_temp_rise = w_temp_rise && w_cell[k].temp_step;
            w_hum_rise  = w_hum_rise && w_cell[k].hum_step;
            w_air_rise  = w_air_rise && w_cell[k].air_step;
        end
        for (int k = 0; k < WINDOW - 1; k++) begin
            w_temp_exc = w_temp_exc || w_cell[k].temp_exceed;
            w_air_exc  = w_air_exc || w_cell[k].air_exceed;
        end
    end

    assign w_full = w_cell[WINDOW-2].valid;

    always_comb begin
        priority if (w_temp_rise || w_temp_exc) begin
            n_code = HZ_TEMP;
        end else if (w_hum_rise) begin
            n_code = HZ_HUMIDITY;
        end else if (w_air_rise || w_air_exc) begin
            n_code = HZ_AIR;
        end else begin
            n_code = HZ_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && w_full) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_full) begin
            r_code <= n_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hazard_code = r_code;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_full_gives_code, w_in_accept && w_full, r_out_valid, "full window gave no code")
    `ASSERT_ALWAYS(a_code_needs_full, !$rose(r_out_valid) || w_full, "code before window full")
    `ASSERT_ALWAYS(a_fill_order, !w_full || w_cell[0].valid, "window cells filled out of order")

endmodule
